// File: hw/rtl/toq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toq_pkg
// Types and codes shared by the time-ordered event queue and its cells.
// ----------------------------------------------------------------------------
package toq_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned TypeW   = 8;
  localparam int unsigned TagW    = 16;
  localparam int unsigned ActionW = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 7;

  localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActionW-1:0] ACT_PEEK   = 2'd1;
  localparam logic [ActionW-1:0] ACT_REMOVE = 2'd2;

  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL = 2'd1;
  localparam logic [StatusW-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [TimeW-1:0]   event_time;
    logic [TypeW-1:0]   event_type;
    logic [TagW-1:0]    event_tag;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               head_valid;
    logic [TimeW-1:0]   head_time;
    logic [TypeW-1:0]   head_type;
    logic [TagW-1:0]    head_tag;
    logic [OccW-1:0]    occupancy;
  } res_t;

  typedef struct packed {
    logic [TimeW-1:0] ev_time;
    logic [TypeW-1:0] ev_type;
    logic [TagW-1:0]  ev_tag;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/toq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toq_cell
// One slot of the sorted chain: compares against the broadcast item and
// takes its own, its left or its right neighbour's entry.
// ----------------------------------------------------------------------------
module toq_cell (
  input  wire logic            clk_i,
  input  wire toq_pkg::cmd_t   cmd_i,
  input  wire logic            occupied_i,
  input  wire logic            left_keep_i,
  input  wire logic            shift_i,
  input  wire toq_pkg::entry_t left_i,
  input  wire toq_pkg::entry_t right_i,
  output logic                 keep_o,
  output logic                 hit_o,
  output toq_pkg::entry_t      entry_o
);

  toq_pkg::entry_t entry_q, entry_d;

  // equal times stay ahead of the new item
  assign keep_o  = occupied_i && (entry_q.ev_time <= cmd_i.entry.ev_time);
  assign hit_o   = occupied_i && (entry_q.ev_tag == cmd_i.entry.ev_tag);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? cmd_i.entry : left_i;
      end
    end else if (cmd_i.rem) begin
      if (shift_i) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/toq_prefix_or.sv
`default_nettype none
// ----------------------------------------------------------------------------
// toq_prefix_or
// Inclusive prefix OR over the cell hit flags, log-depth tree.
// ----------------------------------------------------------------------------
module toq_prefix_or #(
  parameter int unsigned N = 64
) (
  input  wire logic [N-1:0] hit_i,
  output logic      [N-1:0] pref_o
);

  localparam int unsigned Levels = $clog2(N);

  logic [N-1:0] lvl [Levels+1];

  assign lvl[0] = hit_i;

  for (genvar l = 0; l < Levels; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign pref_o = lvl[Levels];

endmodule
`default_nettype wire

// File: hw/rtl/time_ordered_event_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_ordered_event_queue_top
// Sorted event queue built as a chain of cells, earliest event in cell 0.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------
//  request  | start & !busy             | req_i  (toq_pkg::req_t)
//  result   | res_valid_o, one cycle    | res_o  (toq_pkg::res_t)
//
//  One item per cycle: every cell compares and shifts in the cycle the item
//  is taken, and the result strobes in the following cycle. busy stays low.
//  The remove path is set by the tag compare and the log-depth prefix OR
//  that picks the first matching cell.
//  Reset clears the count, the status and the result strobe; cell contents are left.
//  The receiver cannot stall; results are shown for one cycle only.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire toq_pkg::req_t req_i,
  output logic               res_valid_o,
  output toq_pkg::res_t      res_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]                count_q, count_d;
  logic                           valid_q;
  logic [toq_pkg::StatusW-1:0]    status_q, status_d;

  toq_pkg::cmd_t                  cmd;
  toq_pkg::entry_t                entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]         keep, hit, pref;

  logic accept, full, found, do_ins, do_rem;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign found  = pref[QUEUE_DEPTH-1];

  assign do_ins = accept && (req_i.action == toq_pkg::ACT_INSERT) && !full;
  assign do_rem = accept && (req_i.action == toq_pkg::ACT_REMOVE);

  assign cmd.ins            = do_ins;
  assign cmd.rem            = do_rem;
  assign cmd.entry.ev_time  = req_i.event_time;
  assign cmd.entry.ev_type  = req_i.event_type;
  assign cmd.entry.ev_tag   = req_i.event_tag;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            occupied;
    logic            left_keep;
    toq_pkg::entry_t left_e, right_e;

    assign occupied = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_e    = cmd.entry;
    end else begin : g_mid
      assign left_keep = keep[i-1];
      assign left_e    = entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_notlast
      assign right_e = entry[i+1];
    end

    toq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (occupied),
      .left_keep_i (left_keep),
      .shift_i     (pref[i]),
      .left_i      (left_e),
      .right_i     (right_e),
      .keep_o      (keep[i]),
      .hit_o       (hit[i]),
      .entry_o     (entry[i])
    );
  end

  toq_prefix_or #(
    .N (QUEUE_DEPTH)
  ) u_prefix (
    .hit_i  (hit),
    .pref_o (pref)
  );

  always_comb begin
    count_d  = count_q;
    status_d = toq_pkg::ST_OK;
    case (req_i.action)
      toq_pkg::ACT_INSERT: begin
        if (full) begin
          status_d = toq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      toq_pkg::ACT_PEEK: begin
        if (count_q == '0) begin
          status_d = toq_pkg::ST_MISS;
        end
      end
      toq_pkg::ACT_REMOVE: begin
        if (found) begin
          count_d = count_q - CntW'(1);
        end else begin
          status_d = toq_pkg::ST_MISS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= toq_pkg::ST_OK;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  // head read straight from cell 0, zeroed when empty
  logic nonempty;
  assign nonempty = (count_q != '0);

  assign res_valid_o      = valid_q;
  assign res_o.status     = status_q;
  assign res_o.head_valid = nonempty;
  assign res_o.head_time  = nonempty ? entry[0].ev_time : '0;
  assign res_o.head_type  = nonempty ? entry[0].ev_type : '0;
  assign res_o.head_tag   = nonempty ? entry[0].ev_tag  : '0;
  assign res_o.occupancy  = toq_pkg::OccW'(count_q);

endmodule
`default_nettype wire
